@@ rtl/thermostat_hysteresis_control_defines.svh @@
// Assertion macros for the thermostat control block.
`ifndef THERMOSTAT_HYSTERESIS_CONTROL_DEFINES_SVH
`define THERMOSTAT_HYSTERESIS_CONTROL_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define THC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thermostat control: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define THC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thermostat control: next-cycle check failed");

`endif

@@ rtl/thc_pkg.sv @@
package thc_pkg;

    // Configuration register indexes
    localparam int CfgIdxBits = 3;
    localparam logic [CfgIdxBits-1:0] CFG_HEAT_SP_MIN = 3'd0;
    localparam logic [CfgIdxBits-1:0] CFG_HEAT_SP_MAX = 3'd1;
    localparam logic [CfgIdxBits-1:0] CFG_COOL_SP_MIN = 3'd2;
    localparam logic [CfgIdxBits-1:0] CFG_COOL_SP_MAX = 3'd3;
    localparam logic [CfgIdxBits-1:0] CFG_HYST_MIN    = 3'd4;
    localparam logic [CfgIdxBits-1:0] CFG_HYST_MAX    = 3'd5;
    localparam logic [CfgIdxBits-1:0] CFG_TIMER_STEP  = 3'd6;
    localparam logic [CfgIdxBits-1:0] CFG_TIMER_LIMIT = 3'd7;

    localparam int HystBits = 8;
    localparam logic [HystBits-1:0] HYST_RESET = 8'd1;

    // Setpoint button bit positions
    localparam int BTN_RAISE = 0;
    localparam int BTN_LOWER = 1;

    typedef struct packed {
        logic       power_toggle;
        logic       hyst_valid;
        logic [1:0] setpoint_buttons;
        logic       heat_sp_valid;
        logic       cool_sp_valid;
        logic       hold_press;
        logic       timer_valid;
    } thc_events_t;

endpackage

@@ rtl/thermostat_hysteresis_control.sv @@
// An accepted item is held in the input register, then updates the state and
// result registers once the result slot is free or being emptied.
// Throughput: one item per cycle while results are taken; one update stage.
// The result outputs are the state registers themselves, held until taken.
// Reset (rst_n low, asynchronous): power on, hysteresis 1, setpoints and hold
// timer zero, no demand, limits at their full range, timer step 1.
`include "thermostat_hysteresis_control_defines.svh"

module thermostat_hysteresis_control #(
    parameter int TEMP_BITS  = 12,
    parameter int TIMER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [thc_pkg::CfgIdxBits-1:0] cfg_index,
    input  logic [((TEMP_BITS > TIMER_BITS) ? TEMP_BITS : TIMER_BITS)-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        power_toggle,
    input  logic [TEMP_BITS-1:0]        temperature,
    input  logic                        hyst_valid,
    input  logic [thc_pkg::HystBits-1:0] hyst_value,
    input  logic [1:0]                  setpoint_buttons,
    input  logic                        heat_sp_valid,
    input  logic [TEMP_BITS-1:0]        heat_sp_value,
    input  logic                        cool_sp_valid,
    input  logic [TEMP_BITS-1:0]        cool_sp_value,
    input  logic                        hold_press,
    input  logic                        timer_valid,
    input  logic [TIMER_BITS-1:0]       timer_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        power_on,
    output logic                        heating,
    output logic                        cooling,
    output logic [TEMP_BITS-1:0]        heat_sp_now,
    output logic [TEMP_BITS-1:0]        cool_sp_now,
    output logic [TIMER_BITS-1:0]       hold_left
);
    import thc_pkg::*;

    // Configuration registers
    logic [TEMP_BITS-1:0]  heat_sp_min_reg;
    logic [TEMP_BITS-1:0]  heat_sp_max_reg;
    logic [TEMP_BITS-1:0]  cool_sp_min_reg;
    logic [TEMP_BITS-1:0]  cool_sp_max_reg;
    logic [HystBits-1:0]   hyst_min_reg;
    logic [HystBits-1:0]   hyst_max_reg;
    logic [TIMER_BITS-1:0] timer_step_reg;
    logic [TIMER_BITS-1:0] timer_limit_reg;

    // Input stage
    logic                  in_valid_reg;
    thc_events_t           ev_reg;
    thc_events_t           ev_in;
    logic [TEMP_BITS-1:0]  temperature_reg;
    logic [HystBits-1:0]   hyst_value_reg;
    logic [TEMP_BITS-1:0]  heat_sp_value_reg;
    logic [TEMP_BITS-1:0]  cool_sp_value_reg;
    logic [TIMER_BITS-1:0] timer_value_reg;

    // State, doubling as the result register
    logic                  out_valid_reg;
    logic                  power_reg;
    logic [HystBits-1:0]   hyst_reg;
    logic [TEMP_BITS-1:0]  heat_sp_reg;
    logic [TEMP_BITS-1:0]  cool_sp_reg;
    logic [TIMER_BITS-1:0] hold_reg;
    logic                  heat_act_reg;
    logic                  cool_act_reg;

    logic                  power_next;
    logic [HystBits-1:0]   hyst_next;
    logic [TEMP_BITS-1:0]  heat_sp_next;
    logic [TEMP_BITS-1:0]  cool_sp_next;
    logic [TIMER_BITS-1:0] hold_next;
    logic                  heat_act_next;
    logic                  cool_act_next;

    logic                  adv;
    logic                  in_fire;

    // Advance when the result slot is free or being emptied
    assign adv      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || adv;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        ev_in.power_toggle     = power_toggle;
        ev_in.hyst_valid       = hyst_valid;
        ev_in.setpoint_buttons = setpoint_buttons;
        ev_in.heat_sp_valid    = heat_sp_valid;
        ev_in.cool_sp_valid    = cool_sp_valid;
        ev_in.hold_press       = hold_press;
        ev_in.timer_valid      = timer_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_sp_min_reg <= '0;
            heat_sp_max_reg <= '1;
            cool_sp_min_reg <= '0;
            cool_sp_max_reg <= '1;
            hyst_min_reg    <= '0;
            hyst_max_reg    <= '1;
            timer_step_reg  <= TIMER_BITS'(1);
            timer_limit_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAT_SP_MIN: heat_sp_min_reg <= cfg_data[TEMP_BITS-1:0];
                CFG_HEAT_SP_MAX: heat_sp_max_reg <= cfg_data[TEMP_BITS-1:0];
                CFG_COOL_SP_MIN: cool_sp_min_reg <= cfg_data[TEMP_BITS-1:0];
                CFG_COOL_SP_MAX: cool_sp_max_reg <= cfg_data[TEMP_BITS-1:0];
                CFG_HYST_MIN:    hyst_min_reg    <= cfg_data[HystBits-1:0];
                CFG_HYST_MAX:    hyst_max_reg    <= cfg_data[HystBits-1:0];
                CFG_TIMER_STEP:  timer_step_reg  <= cfg_data[TIMER_BITS-1:0];
                CFG_TIMER_LIMIT: timer_limit_reg <= cfg_data[TIMER_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ev_reg            <= ev_in;
            temperature_reg   <= temperature;
            hyst_value_reg    <= hyst_value;
            heat_sp_value_reg <= heat_sp_value;
            cool_sp_value_reg <= cool_sp_value;
            timer_value_reg   <= timer_value;
        end
    end

    thc_update #(
        .TEMP_BITS  (TEMP_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_update (
        .ev            (ev_reg),
        .temperature   (temperature_reg),
        .hyst_value    (hyst_value_reg),
        .heat_sp_value (heat_sp_value_reg),
        .cool_sp_value (cool_sp_value_reg),
        .timer_value   (timer_value_reg),
        .heat_sp_min   (heat_sp_min_reg),
        .heat_sp_max   (heat_sp_max_reg),
        .cool_sp_min   (cool_sp_min_reg),
        .cool_sp_max   (cool_sp_max_reg),
        .hyst_min      (hyst_min_reg),
        .hyst_max      (hyst_max_reg),
        .timer_step    (timer_step_reg),
        .timer_limit   (timer_limit_reg),
        .power_cur     (power_reg),
        .hyst_cur      (hyst_reg),
        .heat_sp_cur   (heat_sp_reg),
        .cool_sp_cur   (cool_sp_reg),
        .hold_cur      (hold_reg),
        .heat_act_cur  (heat_act_reg),
        .cool_act_cur  (cool_act_reg),
        .power_next    (power_next),
        .hyst_next     (hyst_next),
        .heat_sp_next  (heat_sp_next),
        .cool_sp_next  (cool_sp_next),
        .hold_next     (hold_next),
        .heat_act_next (heat_act_next),
        .cool_act_next (cool_act_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            power_reg     <= 1'b1;
            hyst_reg      <= HYST_RESET;
            heat_sp_reg   <= '0;
            cool_sp_reg   <= '0;
            hold_reg      <= '0;
            heat_act_reg  <= 1'b0;
            cool_act_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                power_reg     <= power_next;
                hyst_reg      <= hyst_next;
                heat_sp_reg   <= heat_sp_next;
                cool_sp_reg   <= cool_sp_next;
                hold_reg      <= hold_next;
                heat_act_reg  <= heat_act_next;
                cool_act_reg  <= cool_act_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign power_on    = power_reg;
    assign heating     = heat_act_reg;
    assign cooling     = cool_act_reg;
    assign heat_sp_now = heat_sp_reg;
    assign cool_sp_now = cool_sp_reg;
    assign hold_left   = hold_reg;

    `THC_ASSERT_NOW(a_demand_exclusive, 1'b1, !(heating && cooling))
    `THC_ASSERT_NEXT(a_adv_gives_result, adv, out_valid)
    `THC_ASSERT_NEXT(a_stage_holds, in_valid_reg && !adv, in_valid_reg)
    `THC_ASSERT_NEXT(a_state_frozen, !adv, $stable(hold_left) && $stable(heat_sp_now) && $stable(power_on))

endmodule

@@ rtl/thc_update.sv @@
module thc_update #(
    parameter int TEMP_BITS  = 12,
    parameter int TIMER_BITS = 16
) (
    input  thc_pkg::thc_events_t        ev,
    input  logic [TEMP_BITS-1:0]        temperature,
    input  logic [thc_pkg::HystBits-1:0] hyst_value,
    input  logic [TEMP_BITS-1:0]        heat_sp_value,
    input  logic [TEMP_BITS-1:0]        cool_sp_value,
    input  logic [TIMER_BITS-1:0]       timer_value,
    input  logic [TEMP_BITS-1:0]        heat_sp_min,
    input  logic [TEMP_BITS-1:0]        heat_sp_max,
    input  logic [TEMP_BITS-1:0]        cool_sp_min,
    input  logic [TEMP_BITS-1:0]        cool_sp_max,
    input  logic [thc_pkg::HystBits-1:0] hyst_min,
    input  logic [thc_pkg::HystBits-1:0] hyst_max,
    input  logic [TIMER_BITS-1:0]       timer_step,
    input  logic [TIMER_BITS-1:0]       timer_limit,
    input  logic                        power_cur,
    input  logic [thc_pkg::HystBits-1:0] hyst_cur,
    input  logic [TEMP_BITS-1:0]        heat_sp_cur,
    input  logic [TEMP_BITS-1:0]        cool_sp_cur,
    input  logic [TIMER_BITS-1:0]       hold_cur,
    input  logic                        heat_act_cur,
    input  logic                        cool_act_cur,
    output logic                        power_next,
    output logic [thc_pkg::HystBits-1:0] hyst_next,
    output logic [TEMP_BITS-1:0]        heat_sp_next,
    output logic [TEMP_BITS-1:0]        cool_sp_next,
    output logic [TIMER_BITS-1:0]       hold_next,
    output logic                        heat_act_next,
    output logic                        cool_act_next
);
    import thc_pkg::*;

    // Signed width covering setpoint plus or minus the band
    localparam int SW = TEMP_BITS + HystBits + 2;

    logic [HystBits-1:0]   hyst_up;
    logic [TIMER_BITS-1:0] hold_dec;
    logic [TIMER_BITS:0]   hold_sum;
    logic [TIMER_BITS-1:0] hold_press_val;
    logic signed [SW-1:0]  t_s;
    logic signed [SW-1:0]  heat_s;
    logic signed [SW-1:0]  cool_s;
    logic signed [SW-1:0]  h_s;

    // Upper clamp first, so inverted limits give the minimum
    function automatic logic [TEMP_BITS-1:0] sp_clamp(
        input logic [TEMP_BITS-1:0] v,
        input logic [TEMP_BITS-1:0] mn,
        input logic [TEMP_BITS-1:0] mx
    );
        logic [TEMP_BITS-1:0] up;
        up = (v < mx) ? v : mx;
        return (up > mn) ? up : mn;
    endfunction

    // Raise then lower, each clamped on one side; lowering at zero saturates
    function automatic logic [TEMP_BITS-1:0] sp_step(
        input logic [TEMP_BITS-1:0] sp,
        input logic [TEMP_BITS-1:0] mn,
        input logic [TEMP_BITS-1:0] mx,
        input logic                 raise,
        input logic                 lower
    );
        logic [TEMP_BITS:0]   inc;
        logic [TEMP_BITS-1:0] r;
        logic [TEMP_BITS-1:0] dec;
        logic [TEMP_BITS-1:0] l;
        inc = {1'b0, sp} + (TEMP_BITS+1)'(1);
        if (raise)
            r = (inc < {1'b0, mx}) ? inc[TEMP_BITS-1:0] : mx;
        else
            r = sp;
        dec = (r == '0) ? '0 : r - TEMP_BITS'(1);
        if (lower)
            l = (dec > mn) ? dec : mn;
        else
            l = r;
        return l;
    endfunction

    always_comb
    begin
        power_next = power_cur ^ ev.power_toggle;

        hyst_up = (hyst_value < hyst_max) ? hyst_value : hyst_max;
        if (ev.hyst_valid)
            hyst_next = (hyst_up > hyst_min) ? hyst_up : hyst_min;
        else
            hyst_next = hyst_cur;

        if (ev.heat_sp_valid)
            heat_sp_next = sp_clamp(heat_sp_value, heat_sp_min, heat_sp_max);
        else
            heat_sp_next = sp_step(heat_sp_cur, heat_sp_min, heat_sp_max,
                                   ev.setpoint_buttons[BTN_RAISE],
                                   ev.setpoint_buttons[BTN_LOWER]);
        if (ev.cool_sp_valid)
            cool_sp_next = sp_clamp(cool_sp_value, cool_sp_min, cool_sp_max);
        else
            cool_sp_next = sp_step(cool_sp_cur, cool_sp_min, cool_sp_max,
                                   ev.setpoint_buttons[BTN_RAISE],
                                   ev.setpoint_buttons[BTN_LOWER]);

        // Count down, saturating at zero
        hold_dec = (hold_cur > timer_step) ? hold_cur - timer_step : '0;
        hold_sum = {1'b0, hold_dec} + {1'b0, timer_step};
        if (hold_dec == timer_limit)
            hold_press_val = '0;
        else
            hold_press_val = (hold_sum < {1'b0, timer_limit}) ?
                             hold_sum[TIMER_BITS-1:0] : timer_limit;

        if (ev.timer_valid)
            hold_next = (timer_value < timer_limit) ? timer_value : timer_limit;
        else if (ev.hold_press)
            hold_next = hold_press_val;
        else
            hold_next = hold_dec;

        // Band edges compared signed so heat - h never wraps
        t_s    = $signed({{(SW-TEMP_BITS){1'b0}}, temperature});
        heat_s = $signed({{(SW-TEMP_BITS){1'b0}}, heat_sp_next});
        cool_s = $signed({{(SW-TEMP_BITS){1'b0}}, cool_sp_next});
        h_s    = $signed({{(SW-HystBits){1'b0}}, hyst_next});

        if ((t_s <= heat_s - h_s) || (heat_act_cur && (t_s <= heat_s + h_s)))
        begin
            heat_act_next = 1'b1;
            cool_act_next = 1'b0;
        end
        else if ((t_s >= cool_s + h_s) || (cool_act_cur && (t_s >= cool_s - h_s)))
        begin
            heat_act_next = 1'b0;
            cool_act_next = 1'b1;
        end
        else
        begin
            heat_act_next = 1'b0;
            cool_act_next = 1'b0;
        end
    end

endmodule
